### design/kpd_pkg.sv
// Shared constants and types for the matrix keypad scanner.
// No dependencies; every other file of the block imports this package.
package kpd_pkg;

   // Keypad geometry
   localparam int ROWS = 3;
   localparam int COLS = 3;

   // Field widths
   localparam int ROW_W      = 2;
   localparam int COL_W      = 2;
   localparam int DRV_W      = 3;
   localparam int LINES_W    = 3;
   localparam int PERIOD_W   = 20;
   localparam int SETTLE_W   = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;
   localparam int REQ_W      = 8;
   localparam int RSP_W      = 8;

   // Register reset values and limits
   localparam logic [SETTLE_W-1:0] SETTLE_MAX     = SETTLE_W'(20);
   localparam logic [SETTLE_W-1:0] SETTLE_DEFAULT = SETTLE_W'(5);
   localparam logic [PERIOD_W-1:0] PERIOD_RESET   = PERIOD_W'(50000);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SETTLE = 2'd2;

   typedef logic [ROWS-1:0][COLS-1:0] key_grid_type;

   // Controller to datapath
   typedef struct packed {
      logic tick;   // input transaction accepted this cycle
      logic step;   // advance the change walk by one key
      logic emit;   // current walk key changed: load an event result
   } kpd_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;    // result register can take a new result
      logic walk_start;  // a tick now would end a scan with changes to report
      logic cur_set;     // walk key under the cursor has changed
      logic rest_zero;   // no other changed key remains after the cursor
   } kpd_sts_type;

endpackage

### design/kpd_datapath.sv
// Datapath of the keypad scanner: registers, scan timing, key map,
// change walk and the result register. Depends on kpd_pkg.
module kpd_datapath import kpd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic [LINES_W-1:0]    col_lines,
   input  kpd_cmd_type           cmd,
   output kpd_sts_type           sts,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_WAIT  = 2'd1;
   localparam logic [1:0] PH_DRIVE = 2'd2;

   logic                enable_ff, enable_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [SETTLE_W-1:0] settle_ff, settle_in;
   logic [1:0]          phase_ff, phase_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [SETTLE_W-1:0] settle_cnt_ff, settle_cnt_in;
   logic [PERIOD_W-1:0] period_cnt_ff, period_cnt_in;
   logic                baseline_ff, baseline_in;
   key_grid_type        key_map_ff, key_map_in;
   key_grid_type        scan_bits_ff, scan_bits_in;
   key_grid_type        chg_ff, chg_in;
   logic [ROW_W-1:0]    walk_row_ff, walk_row_in;
   logic [COL_W-1:0]    walk_col_ff, walk_col_in;
   logic [DRV_W-1:0]    drive_ff, drive_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DRV_W-1:0]    rsp_drive_ff, rsp_drive_in;
   logic                rsp_event_ff, rsp_event_in;
   logic [ROW_W-1:0]    rsp_row_ff, rsp_row_in;
   logic [COL_W-1:0]    rsp_col_ff, rsp_col_in;
   logic                rsp_pressed_ff, rsp_pressed_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [ROW_W-1:0]    cur_row;
   logic [DRV_W-1:0]    drive_now;
   logic                sample;
   logic                scan_end;
   key_grid_type        new_bits;
   key_grid_type        chg_new;
   key_grid_type        chg_rest;
   logic [PERIOD_W-1:0] period_inc;
   logic [SETTLE_W-1:0] settle_wr;
   logic                out_free;
   logic                walk_start;
   logic                cur_set;

   // Decode the current scan row and what a tick would sample now
   always_comb begin
      cur_row   = (row_ff >= ROW_W'(ROWS)) ? '0 : row_ff;
      drive_now = '1;
      if (phase_ff == PH_DRIVE) begin
         drive_now = ~(DRV_W'(1) << cur_row);
      end
      sample   = (settle_cnt_ff >= settle_ff);
      new_bits = scan_bits_ff;
      new_bits[cur_row] = ~col_lines[COLS-1:0];
      scan_end = (phase_ff == PH_DRIVE) && sample && (cur_row == ROW_W'(ROWS - 1));
      chg_new  = key_map_ff ^ new_bits;
      walk_start = scan_end && baseline_ff && (chg_new != '0);
      period_inc = period_cnt_ff + PERIOD_W'(1);
   end

   // Walk cursor over the change map
   always_comb begin
      cur_set  = chg_ff[walk_row_ff][walk_col_ff];
      chg_rest = chg_ff;
      chg_rest[walk_row_ff][walk_col_ff] = 1'b0;
   end

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign settle_wr = (csr_data[SETTLE_W-1:0] > SETTLE_MAX) ? SETTLE_DEFAULT
                                                           : csr_data[SETTLE_W-1:0];

   always_comb begin
      sts.out_free   = out_free;
      sts.walk_start = walk_start;
      sts.cur_set    = cur_set;
      sts.rest_zero  = (chg_rest == '0);
   end

   // Next state of the scan sequencer, the walk and the configuration
   always_comb begin
      enable_in     = enable_ff;
      period_in     = period_ff;
      settle_in     = settle_ff;
      phase_in      = phase_ff;
      row_in        = row_ff;
      settle_cnt_in = settle_cnt_ff;
      period_cnt_in = period_cnt_ff;
      baseline_in   = baseline_ff;
      key_map_in    = key_map_ff;
      scan_bits_in  = scan_bits_ff;
      chg_in        = chg_ff;
      walk_row_in   = walk_row_ff;
      walk_col_in   = walk_col_ff;
      drive_in      = drive_ff;

      // Advance the scan on each tick
      if (cmd.tick) begin
         unique case (phase_ff)
            PH_WAIT: begin
               if (period_inc >= period_ff || period_inc == '0) begin
                  phase_in      = PH_DRIVE;
                  row_in        = '0;
                  settle_cnt_in = '0;
                  period_cnt_in = '0;
               end else begin
                  period_cnt_in = period_inc;
               end
            end
            PH_DRIVE: begin
               if (sample) begin
                  scan_bits_in  = new_bits;
                  settle_cnt_in = '0;
                  if (scan_end) begin
                     key_map_in    = new_bits;
                     baseline_in   = 1'b1;
                     phase_in      = PH_WAIT;
                     row_in        = '0;
                     period_cnt_in = '0;
                  end else begin
                     row_in = cur_row + ROW_W'(1);
                  end
               end else begin
                  settle_cnt_in = settle_cnt_ff + SETTLE_W'(1);
               end
            end
            default: begin
            end
         endcase
         if (walk_start) begin
            chg_in      = chg_new;
            walk_row_in = '0;
            walk_col_in = '0;
            drive_in    = drive_now;
         end
      end

      // Step the walk cursor in row-then-column order
      if (cmd.step) begin
         if (walk_col_ff == COL_W'(COLS - 1)) begin
            walk_col_in = '0;
            walk_row_in = walk_row_ff + ROW_W'(1);
         end else begin
            walk_col_in = walk_col_ff + COL_W'(1);
         end
         if (cmd.emit) begin
            chg_in = chg_rest;
         end
      end

      // Register writes
      if (csr_valid) begin
         unique case (csr_index)
            REG_ENABLE: begin
               if (csr_data[0] && !enable_ff) begin
                  phase_in      = PH_DRIVE;
                  row_in        = '0;
                  settle_cnt_in = '0;
                  period_cnt_in = '0;
                  baseline_in   = 1'b0;
               end else if (!csr_data[0]) begin
                  phase_in      = PH_IDLE;
                  row_in        = '0;
                  settle_cnt_in = '0;
                  period_cnt_in = '0;
               end
               enable_in = csr_data[0];
            end
            REG_PERIOD: period_in = csr_data[PERIOD_W-1:0];
            REG_SETTLE: settle_in = settle_wr;
            default: begin
            end
         endcase
      end
   end

   // Load the result register: a plain tick result or one key event
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_drive_in   = rsp_drive_ff;
      rsp_event_in   = rsp_event_ff;
      rsp_row_in     = rsp_row_ff;
      rsp_col_in     = rsp_col_ff;
      rsp_pressed_in = rsp_pressed_ff;
      rsp_last_in    = rsp_last_ff;
      if (cmd.tick && !walk_start) begin
         rsp_valid_in   = 1'b1;
         rsp_drive_in   = drive_now;
         rsp_event_in   = 1'b0;
         rsp_row_in     = '0;
         rsp_col_in     = '0;
         rsp_pressed_in = 1'b0;
         rsp_last_in    = 1'b1;
      end else if (cmd.emit) begin
         rsp_valid_in   = 1'b1;
         rsp_drive_in   = drive_ff;
         rsp_event_in   = 1'b1;
         rsp_row_in     = walk_row_ff;
         rsp_col_in     = walk_col_ff;
         rsp_pressed_in = key_map_ff[walk_row_ff][walk_col_ff];
         rsp_last_in    = sts.rest_zero;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b0;
         period_ff     <= PERIOD_RESET;
         settle_ff     <= SETTLE_DEFAULT;
         phase_ff      <= PH_IDLE;
         row_ff        <= '0;
         settle_cnt_ff <= '0;
         period_cnt_ff <= '0;
         baseline_ff   <= 1'b0;
         key_map_ff    <= '0;
         scan_bits_ff  <= '0;
         chg_ff        <= '0;
         walk_row_ff   <= '0;
         walk_col_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         enable_ff     <= enable_in;
         period_ff     <= period_in;
         settle_ff     <= settle_in;
         phase_ff      <= phase_in;
         row_ff        <= row_in;
         settle_cnt_ff <= settle_cnt_in;
         period_cnt_ff <= period_cnt_in;
         baseline_ff   <= baseline_in;
         key_map_ff    <= key_map_in;
         scan_bits_ff  <= scan_bits_in;
         chg_ff        <= chg_in;
         walk_row_ff   <= walk_row_in;
         walk_col_ff   <= walk_col_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      drive_ff       <= drive_in;
      rsp_drive_ff   <= rsp_drive_in;
      rsp_event_ff   <= rsp_event_in;
      rsp_row_ff     <= rsp_row_in;
      rsp_col_ff     <= rsp_col_in;
      rsp_pressed_ff <= rsp_pressed_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_pressed_ff, rsp_col_ff, rsp_row_ff, rsp_drive_ff};
   assign rsp_tuser  = rsp_event_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### design/kpd_control.sv
// Controller of the keypad scanner: takes tick transactions and sequences
// the walk over changed keys at the end of a scan. Depends on kpd_pkg.
module kpd_control import kpd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  kpd_sts_type sts,
   output kpd_cmd_type cmd
);

   localparam logic ST_TICK = 1'b0;
   localparam logic ST_WALK = 1'b1;

   logic state_ff, state_in;

   // Take a tick only when the result register can hold its result
   assign req_tready = (state_ff == ST_TICK) && sts.out_free;

   always_comb begin
      cmd.tick = req_tready && req_tvalid;
      cmd.step = (state_ff == ST_WALK) && (!sts.cur_set || sts.out_free);
      cmd.emit = cmd.step && sts.cur_set;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_TICK: if (cmd.tick && sts.walk_start) state_in = ST_WALK;
         ST_WALK: if (cmd.emit && sts.rest_zero) state_in = ST_TICK;
         default: state_in = ST_TICK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_TICK;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### design/matrix_keypad_scanner.sv
// Matrix keypad scanner top level: controller and datapath.
// Depends on kpd_pkg, kpd_control and kpd_datapath.
//
// Usage: each req transaction is one tick carrying the active-low column
// levels in req_tdata[2:0]. Every tick gives at least one rsp transaction
// with the row drive of that tick; a scan-ending tick with key changes gives
// one event per changed key (tuser high) in row-then-column order, tlast on
// the final one. Registers are written on the csr channel (index 0 enable,
// 1 period, 2 settle), which is always ready; write them only while idle.
// A plain result is valid in the cycle after its tick is accepted; the
// first event of a walk comes after the walk state is entered and the
// cursor has stepped past each unchanged key ahead of it. The next tick
// is taken in the cycle its result is taken. A tick that ends a scan with
// changes walks the ROWS*COLS change map one key per cycle, while the
// receiver does not stall an event, through the shared result register.
// Reset clears the key map, stops scanning and loads period 50000 and
// settle 5. While rsp_tready is low the result is held and no tick or
// further event is taken.
module matrix_keypad_scanner import kpd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,   // [2:0] col_lines, [7:3] zero
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,   // [2:0] row_drive_n, [4:3] key_row,
                                              // [6:5] key_col, [7] pressed
   output logic                  rsp_tuser,   // event_valid
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   kpd_cmd_type cmd;
   kpd_sts_type sts;

   assign csr_ready = 1'b1;

   kpd_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   kpd_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .col_lines  (req_tdata[LINES_W-1:0]),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // A tick is never taken while a stalled result still occupies the register
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (!rsp_tvalid || rsp_tready))
      else $error("tick taken while result register blocked");

   // A tick that does not start a walk produces its result next cycle
   a_tick_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !sts.walk_start) |=> rsp_tvalid)
      else $error("tick result missing");

   // Key events are only reported with exactly one row driven
   a_event_drive: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> $onehot(~rsp_tdata[DRV_W-1:0]))
      else $error("event without a single driven row");

   // A result without an event is always the only one of its tick
   a_plain_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> rsp_tlast)
      else $error("plain result without last");

endmodule
